@@ hdl/gbra_pkg.sv @@
// shared constants, codes and controller/datapath link types for the
// grouped bitmap reference-count allocator; no dependencies
package gbra_pkg;

   localparam int CMD_W      = 2;
   localparam int UNIT_W     = 14;
   localparam int STATUS_W   = 3;
   localparam int REFOUT_W   = 16;
   localparam int TOTAL_W    = 14;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;
   localparam int GCFG_W     = 4;
   localparam int UCFG_W     = 11;
   localparam int WORD_BITS  = 32;
   localparam int BIT_W      = 5;

   localparam int GROUPS_DEF          = 8;
   localparam int UNITS_PER_GROUP_DEF = 1024;
   localparam int REF_WIDTH_DEF       = 16;

   localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_REL    = 2'd2;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NOFREE   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOTALLOC = 3'd3;
   localparam logic [STATUS_W-1:0] ST_SAT      = 3'd4;

   localparam logic [CSR_IDX_W-1:0] REG_GROUPS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_UNITS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FIRST  = 2'd2;

   localparam logic [GCFG_W-1:0] GROUPS_RST = 4'd8;
   localparam logic [UCFG_W-1:0] UNITS_RST  = 11'd1024;
   localparam logic              FIRST_RST  = 1'b1;

   typedef enum logic [2:0] {
      RES_NONE,
      RES_NOFREE,
      RES_RANGE,
      RES_NOTALLOC,
      RES_ALLOC,
      RES_REF
   } res_type;

   typedef struct packed {
      logic    clr_step;
      logic    load;
      logic    grp_next;
      logic    div_step;
      logic    word_next;
      logic    rd_alloc;
      logic    rd_lookup;
      logic    finish;
      res_type res;
   } ctl_type;

   typedef struct packed {
      logic clr_last;
      logic group_full;
      logic last_group;
      logic word_free;
      logic last_word;
      logic num_low;
      logic rem_lt_nu;
      logic bit_set;
   } sts_type;

endpackage

@@ hdl/gbra_if.sv @@
// request, response and register-write channel interfaces
// depends on gbra_pkg for field widths
interface gbra_req_if;
   logic                       valid;
   logic                       ready;
   logic [gbra_pkg::CMD_W-1:0]  cmd;
   logic [gbra_pkg::UNIT_W-1:0] unit_number;
   modport source (output valid, cmd, unit_number, input ready);
   modport sink (input valid, cmd, unit_number, output ready);
endinterface

interface gbra_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [gbra_pkg::STATUS_W-1:0] status;
   logic [gbra_pkg::UNIT_W-1:0]   result_unit;
   logic [gbra_pkg::REFOUT_W-1:0] ref_count_after;
   logic                         freed;
   logic [gbra_pkg::TOTAL_W-1:0]  total_used;
   modport source (output valid, status, result_unit, ref_count_after, freed, total_used,
                   input ready);
   modport sink (input valid, status, result_unit, ref_count_after, freed, total_used,
                 output ready);
endinterface

interface gbra_csr_if;
   logic                           valid;
   logic                           ready;
   logic [gbra_pkg::CSR_IDX_W-1:0]  index;
   logic [gbra_pkg::CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ hdl/gbra_ctrl.sv @@
// sequencing state machine: clear pass, group scan, group lookup, reply
// depends on gbra_pkg for command and status types
module gbra_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic [gbra_pkg::CMD_W-1:0] req_cmd,
   input  logic                       rsp_ready,
   input  gbra_pkg::sts_type          sts,
   output gbra_pkg::ctl_type          ctl,
   output logic                       req_ready,
   output logic                       rsp_valid
);

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_AGRP,
      S_ARD,
      S_AWAIT,
      S_DCHK,
      S_DDIV,
      S_DWAIT,
      S_DONE
   } state_type;

   state_type         state_ff, state_in;
   gbra_pkg::res_type res_ff, res_in;
   logic              rsp_valid_ff, rsp_valid_in;

   always_comb begin
      ctl      = '0;
      ctl.res  = res_ff;
      state_in = state_ff;
      res_in   = res_ff;
      case (state_ff)
         S_CLEAR: begin
            ctl.clr_step = 1'b1;
            if (sts.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               ctl.load = 1'b1;
               case (req_cmd)
                  gbra_pkg::CMD_ALLOC: state_in = S_AGRP;
                  gbra_pkg::CMD_ADD:   state_in = S_DCHK;
                  gbra_pkg::CMD_REL:   state_in = S_DCHK;
                  default: begin
                     res_in   = gbra_pkg::RES_NONE;
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_AGRP: begin
            if (sts.group_full) begin
               if (sts.last_group) begin
                  res_in   = gbra_pkg::RES_NOFREE;
                  state_in = S_DONE;
               end else begin
                  ctl.grp_next = 1'b1;
               end
            end else begin
               ctl.rd_alloc = 1'b1;
               state_in     = S_AWAIT;
            end
         end
         S_ARD: begin
            ctl.rd_alloc = 1'b1;
            state_in     = S_AWAIT;
         end
         S_AWAIT: begin
            if (sts.word_free) begin
               res_in   = gbra_pkg::RES_ALLOC;
               state_in = S_DONE;
            end else if (sts.last_word) begin
               if (sts.last_group) begin
                  res_in   = gbra_pkg::RES_NOFREE;
                  state_in = S_DONE;
               end else begin
                  ctl.grp_next = 1'b1;
                  state_in     = S_AGRP;
               end
            end else begin
               ctl.word_next = 1'b1;
               state_in      = S_ARD;
            end
         end
         S_DCHK: begin
            if (sts.num_low) begin
               res_in   = gbra_pkg::RES_RANGE;
               state_in = S_DONE;
            end else begin
               state_in = S_DDIV;
            end
         end
         S_DDIV: begin
            // repeated subtraction of the group size finds group and offset
            if (sts.rem_lt_nu) begin
               ctl.rd_lookup = 1'b1;
               state_in      = S_DWAIT;
            end else if (sts.last_group) begin
               res_in   = gbra_pkg::RES_RANGE;
               state_in = S_DONE;
            end else begin
               ctl.div_step = 1'b1;
            end
         end
         S_DWAIT: begin
            res_in   = sts.bit_set ? gbra_pkg::RES_REF : gbra_pkg::RES_NOTALLOC;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               ctl.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (ctl.finish) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         res_ff       <= gbra_pkg::RES_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         res_ff       <= res_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

@@ hdl/gbra_dp.sv @@
// datapath: registers, bitmap and count memories, group counters, reply payload
// depends on gbra_pkg; driven by gbra_ctrl commands
module gbra_dp #(
   parameter int GROUPS          = gbra_pkg::GROUPS_DEF,
   parameter int UNITS_PER_GROUP = gbra_pkg::UNITS_PER_GROUP_DEF,
   parameter int REF_WIDTH       = gbra_pkg::REF_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  gbra_pkg::ctl_type                 ctl,
   output gbra_pkg::sts_type                 sts,
   input  logic [gbra_pkg::CMD_W-1:0]        req_cmd,
   input  logic [gbra_pkg::UNIT_W-1:0]       req_unit,
   input  logic                              csr_valid,
   input  logic [gbra_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [gbra_pkg::CSR_DATA_W-1:0]   csr_data,
   output logic [gbra_pkg::STATUS_W-1:0]     rsp_status,
   output logic [gbra_pkg::UNIT_W-1:0]       rsp_result_unit,
   output logic [gbra_pkg::REFOUT_W-1:0]     rsp_ref_count_after,
   output logic                              rsp_freed,
   output logic [gbra_pkg::TOTAL_W-1:0]      rsp_total_used
);

   localparam int WB          = gbra_pkg::WORD_BITS;
   localparam int BW          = gbra_pkg::BIT_W;
   localparam int GROUP_WORDS = (UNITS_PER_GROUP + WB - 1) / WB;
   localparam int MEM_WORDS   = GROUPS * GROUP_WORDS;
   localparam int WA_W        = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
   localparam int WI_W        = (GROUP_WORDS > 1) ? $clog2(GROUP_WORDS) : 1;
   localparam int GW          = (GROUPS > 1) ? $clog2(GROUPS) : 1;
   localparam int NGW         = $clog2(GROUPS + 1);
   localparam int NUW         = $clog2(UNITS_PER_GROUP + 1);
   localparam int CNT_W       = $clog2(GROUPS * UNITS_PER_GROUP + 1);
   localparam int RES_W       = CNT_W + 1;
   localparam int UW          = gbra_pkg::UNIT_W;

   // configuration
   logic [gbra_pkg::GCFG_W-1:0] groups_ff;
   logic [gbra_pkg::UCFG_W-1:0] units_ff;
   logic                        first_ff;
   logic [NGW-1:0]              ng;
   logic [NUW-1:0]              nu;

   // working registers
   logic [gbra_pkg::CMD_W-1:0]  cmd_ff;
   logic [UW-1:0]               num_ff;
   logic [UW-1:0]               rem_ff;
   logic [GW-1:0]               g_ff;
   logic [WA_W-1:0]             wbase_ff;
   logic [RES_W-1:0]            base_ff;
   logic [WI_W-1:0]             widx_ff;
   logic [WA_W-1:0]             clr_ff;
   logic [WA_W-1:0]             addr_ff;
   logic [BW-1:0]               rbit_ff;
   logic [WB-1:0]               rdata_ff;
   logic [REF_WIDTH-1:0]        refrd_ff;
   logic [NUW-1:0]              group_used_ff [GROUPS];
   logic [CNT_W-1:0]            total_ff;

   // reply payload
   logic [gbra_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [UW-1:0]                 unit_ff, unit_in;
   logic [gbra_pkg::REFOUT_W-1:0] refs_ff, refs_in;
   logic                          freed_ff, freed_in;
   logic [gbra_pkg::TOTAL_W-1:0]  used_ff, used_in;

   // memories
   logic [WB-1:0]        bm_mem  [MEM_WORDS];
   logic [REF_WIDTH-1:0] ref_mem [MEM_WORDS * WB];

   logic                 rd_en;
   logic [WA_W-1:0]      rd_addr;
   logic [BW-1:0]        rd_bit;
   logic [31:0]          units_left;
   logic [WB-1:0]        mask, free;
   logic [BW-1:0]        fbit;
   logic                 is_add, is_rel, at_max;
   logic [REF_WIDTH-1:0] new_ref;
   logic                 rel_free;
   logic                 bm_we, ref_we;
   logic [WA_W-1:0]      bm_waddr;
   logic [WB-1:0]        bm_wdata;
   logic [BW-1:0]        wbit;
   logic [REF_WIDTH-1:0] ref_wdata;
   logic [CNT_W-1:0]     total_after;
   logic [RES_W-1:0]     alloc_num;

   always_comb begin
      if (groups_ff == '0) ng = NGW'(1);
      else if (32'(groups_ff) > GROUPS) ng = NGW'(GROUPS);
      else ng = NGW'(groups_ff);
      if (units_ff == '0) nu = NUW'(1);
      else if (32'(units_ff) > UNITS_PER_GROUP) nu = NUW'(UNITS_PER_GROUP);
      else nu = NUW'(units_ff);
   end

   // free bit search in the word just read
   always_comb begin
      units_left = 32'(nu) - (32'(widx_ff) << BW);
      for (int b = 0; b < WB; b++) mask[b] = (32'(b) < units_left);
      free = ~rdata_ff & mask;
      fbit = '0;
      for (int b = WB - 1; b >= 0; b--) begin
         if (free[b]) fbit = BW'(b);
      end
   end

   always_comb begin
      sts.clr_last   = (clr_ff == WA_W'(MEM_WORDS - 1));
      sts.group_full = (32'(group_used_ff[g_ff]) >= 32'(nu));
      sts.last_group = (32'(g_ff) + 32'd1 >= 32'(ng));
      sts.word_free  = |free;
      sts.last_word  = (units_left <= WB);
      sts.num_low    = (32'(num_ff) < 32'(first_ff));
      sts.rem_lt_nu  = (32'(rem_ff) < 32'(nu));
      sts.bit_set    = rdata_ff[rbit_ff];
   end

   assign rd_en   = ctl.rd_alloc | ctl.rd_lookup;
   assign rd_addr = ctl.rd_alloc ? WA_W'(32'(wbase_ff) + 32'(widx_ff))
                                 : WA_W'(32'(wbase_ff) + (32'(rem_ff) >> BW));
   assign rd_bit  = ctl.rd_lookup ? rem_ff[BW-1:0] : '0;

   assign is_add   = (cmd_ff == gbra_pkg::CMD_ADD);
   assign is_rel   = (cmd_ff == gbra_pkg::CMD_REL);
   assign at_max   = &refrd_ff;
   assign new_ref  = is_add ? refrd_ff + REF_WIDTH'(1)
                            : ((refrd_ff == '0) ? '0 : refrd_ff - REF_WIDTH'(1));
   assign rel_free = is_rel && (new_ref == '0);

   always_comb begin
      bm_we     = 1'b0;
      bm_waddr  = addr_ff;
      bm_wdata  = rdata_ff;
      ref_we    = 1'b0;
      wbit      = rbit_ff;
      ref_wdata = new_ref;
      total_after = total_ff;
      if (ctl.clr_step) begin
         bm_we    = 1'b1;
         bm_waddr = clr_ff;
         bm_wdata = '0;
      end else if (ctl.finish && ctl.res == gbra_pkg::RES_ALLOC) begin
         bm_we       = 1'b1;
         bm_wdata    = rdata_ff | (WB'(1) << fbit);
         ref_we      = 1'b1;
         wbit        = fbit;
         ref_wdata   = REF_WIDTH'(1);
         total_after = total_ff + CNT_W'(1);
      end else if (ctl.finish && ctl.res == gbra_pkg::RES_REF) begin
         ref_we = !(is_add && at_max);
         if (rel_free) begin
            bm_we    = 1'b1;
            bm_wdata = rdata_ff & ~(WB'(1) << rbit_ff);
            if (total_ff != '0) total_after = total_ff - CNT_W'(1);
         end
      end
   end

   assign alloc_num = base_ff + RES_W'({widx_ff, fbit}) + RES_W'(first_ff);

   always_ff @(posedge clock) begin
      if (bm_we) bm_mem[bm_waddr] <= bm_wdata;
      if (rd_en) rdata_ff <= bm_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (ref_we) ref_mem[{addr_ff, wbit}] <= ref_wdata;
      if (rd_en) refrd_ff <= ref_mem[{rd_addr, rd_bit}];
   end

   // control state: config, counters, clear sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         groups_ff <= gbra_pkg::GROUPS_RST;
         units_ff  <= gbra_pkg::UNITS_RST;
         first_ff  <= gbra_pkg::FIRST_RST;
         clr_ff    <= '0;
         total_ff  <= '0;
         for (int i = 0; i < GROUPS; i++) group_used_ff[i] <= '0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               gbra_pkg::REG_GROUPS: groups_ff <= csr_data[gbra_pkg::GCFG_W-1:0];
               gbra_pkg::REG_UNITS:  units_ff  <= csr_data[gbra_pkg::UCFG_W-1:0];
               gbra_pkg::REG_FIRST:  first_ff  <= csr_data[0];
               default: ;
            endcase
         end
         if (ctl.clr_step) clr_ff <= clr_ff + WA_W'(1);
         total_ff <= total_after;
         if (ctl.finish && ctl.res == gbra_pkg::RES_ALLOC) begin
            group_used_ff[g_ff] <= group_used_ff[g_ff] + NUW'(1);
         end else if (ctl.finish && ctl.res == gbra_pkg::RES_REF && rel_free) begin
            if (group_used_ff[g_ff] != '0) group_used_ff[g_ff] <= group_used_ff[g_ff] - NUW'(1);
         end
      end
   end

   // reply payload for the command that finishes
   always_comb begin
      status_in = gbra_pkg::ST_OK;
      unit_in   = num_ff;
      refs_in   = '0;
      freed_in  = 1'b0;
      used_in   = gbra_pkg::TOTAL_W'(total_after);
      case (ctl.res)
         gbra_pkg::RES_NONE: unit_in = '0;
         gbra_pkg::RES_NOFREE: begin
            status_in = gbra_pkg::ST_NOFREE;
            unit_in   = '0;
         end
         gbra_pkg::RES_RANGE:    status_in = gbra_pkg::ST_RANGE;
         gbra_pkg::RES_NOTALLOC: status_in = gbra_pkg::ST_NOTALLOC;
         gbra_pkg::RES_ALLOC: begin
            unit_in = UW'(alloc_num);
            refs_in = gbra_pkg::REFOUT_W'(1);
         end
         gbra_pkg::RES_REF: begin
            if (is_add && at_max) begin
               status_in = gbra_pkg::ST_SAT;
               refs_in   = gbra_pkg::REFOUT_W'(refrd_ff);
            end else begin
               refs_in  = gbra_pkg::REFOUT_W'(new_ref);
               freed_in = rel_free;
            end
         end
         default: status_in = gbra_pkg::ST_OK;
      endcase
   end

   // working registers and reply registers
   always_ff @(posedge clock) begin
      if (rd_en) begin
         addr_ff <= rd_addr;
         rbit_ff <= rd_bit;
      end
      if (ctl.load) begin
         cmd_ff   <= req_cmd;
         num_ff   <= req_unit;
         rem_ff   <= req_unit - UW'(first_ff);
         g_ff     <= '0;
         wbase_ff <= '0;
         base_ff  <= '0;
         widx_ff  <= '0;
      end
      if (ctl.grp_next) begin
         g_ff     <= g_ff + GW'(1);
         wbase_ff <= wbase_ff + WA_W'(GROUP_WORDS);
         base_ff  <= base_ff + RES_W'(nu);
         widx_ff  <= '0;
      end
      if (ctl.div_step) begin
         rem_ff   <= rem_ff - UW'(nu);
         g_ff     <= g_ff + GW'(1);
         wbase_ff <= wbase_ff + WA_W'(GROUP_WORDS);
      end
      if (ctl.word_next) widx_ff <= widx_ff + WI_W'(1);
      if (ctl.finish) begin
         status_ff <= status_in;
         unit_ff   <= unit_in;
         refs_ff   <= refs_in;
         freed_ff  <= freed_in;
         used_ff   <= used_in;
      end
   end

   assign rsp_status          = status_ff;
   assign rsp_result_unit     = unit_ff;
   assign rsp_ref_count_after = refs_ff;
   assign rsp_freed           = freed_ff;
   assign rsp_total_used      = used_ff;

endmodule

@@ hdl/grouped_bitmap_refcount_allocator_core.sv @@
// Grouped first-fit bitmap allocator with per-unit reference counts.
// Channels: req (cmd, unit_number), rsp (status, result_unit, ref_count_after,
// freed, total_used) and csr (index, data), all valid/ready; a transfer happens
// when both are high. csr is always ready; write it only while no command is open.
// One command is worked at a time. Add reference and release find the unit's group
// index by subtracting the group size once per cycle, then read its bitmap word
// and count. Allocate walks groups with one bitmap memory port: a group whose used
// count shows it full is skipped without a read, else its 32-bit bitmap words are
// read in turn, each read then checked for a free bit, until one is found or the
// last group is done; then the reply is made.
// After reset the bitmap memory is cleared one word per cycle (all GROUPS *
// ceil(UNITS_PER_GROUP / 32) words, 256 at the defaults) with req held not
// ready; config registers return to 8 groups, 1024 units and first number 1.
// The reply sits in an output register; req is taken again while it waits,
// and the next reply holds in its final step until rsp is taken.
// Depends on gbra_pkg, gbra_if, gbra_ctrl and gbra_dp.
module grouped_bitmap_refcount_allocator_core #(
   parameter int GROUPS          = gbra_pkg::GROUPS_DEF,
   parameter int UNITS_PER_GROUP = gbra_pkg::UNITS_PER_GROUP_DEF,
   parameter int REF_WIDTH       = gbra_pkg::REF_WIDTH_DEF
) (
   input logic        clock,
   input logic        reset,
   gbra_req_if.sink   req,
   gbra_rsp_if.source rsp,
   gbra_csr_if.sink   csr
);

   gbra_pkg::ctl_type ctl;
   gbra_pkg::sts_type sts;

   assign csr.ready = 1'b1;

   gbra_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_cmd   (req.cmd),
      .rsp_ready (rsp.ready),
      .sts       (sts),
      .ctl       (ctl),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid)
   );

   gbra_dp #(
      .GROUPS          (GROUPS),
      .UNITS_PER_GROUP (UNITS_PER_GROUP),
      .REF_WIDTH       (REF_WIDTH)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .ctl                 (ctl),
      .sts                 (sts),
      .req_cmd             (req.cmd),
      .req_unit            (req.unit_number),
      .csr_valid           (csr.valid),
      .csr_index           (csr.index),
      .csr_data            (csr.data),
      .rsp_status          (rsp.status),
      .rsp_result_unit     (rsp.result_unit),
      .rsp_ref_count_after (rsp.ref_count_after),
      .rsp_freed           (rsp.freed),
      .rsp_total_used      (rsp.total_used)
   );

   // one command in flight at a time
   a_one_open: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> !req.ready)
      else $error("request taken while a command is open");

   // clear sweep follows reset
   a_clear_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req.ready)
      else $error("request ready during clear sweep");

   a_freed_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.freed) |->
         (rsp.status == gbra_pkg::ST_OK && rsp.ref_count_after == '0))
      else $error("freed reply with nonzero count or bad status");

   a_nofree_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.status == gbra_pkg::ST_NOFREE) |-> (rsp.result_unit == '0))
      else $error("failed allocate returned a unit number");

endmodule
